>>> rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Types and constants shared by the comment-stripping text filter.
// ----------------------------------------------------------------------------
package ccs_pkg;

  // register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgCommentChars = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgQuoteChars   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKeptControls = 2'd2;
  localparam int unsigned CfgDataW = 32;

  // register widths and slot counts
  localparam int unsigned CommentW     = 32;
  localparam int unsigned QuoteW       = 24;
  localparam int unsigned KeptW        = 16;
  localparam int unsigned CommentSlots = CommentW / 8;
  localparam int unsigned QuoteSlots   = QuoteW / 8;
  localparam int unsigned KeptSlots    = KeptW / 8;

  // register reset values: ";#", backquote/single/double quote, newline/tab
  localparam logic [CommentW-1:0] CommentReset = 32'h0000_3B23;
  localparam logic [QuoteW-1:0]   QuoteReset   = 24'h60_2722;
  localparam logic [KeptW-1:0]    KeptReset    = 16'h0A09;

  // characters with a fixed meaning
  localparam logic [7:0] ChUpperA    = 8'h41;
  localparam logic [7:0] ChUpperZ    = 8'h5A;
  localparam logic [7:0] ChDigit0    = 8'h30;
  localparam logic [7:0] ChDigit9    = 8'h39;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChNewline   = 8'h0A;

  // most results one text byte can cause
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ResCntW    = 2;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_text;
  } res_t;

  // results of one text byte, handed from the scanner to the output buffer
  typedef struct packed {
    logic [ResCntW-1:0]          cnt;
    res_t [MaxResults-1:0]       res;
  } grp_t;

endpackage

>>> rtl/ccs_in_if.sv
// ----------------------------------------------------------------------------
// ccs_in_if
// Raw text channel: one byte and its last flag per transfer.
// ----------------------------------------------------------------------------
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

>>> rtl/ccs_out_if.sv
// ----------------------------------------------------------------------------
// ccs_out_if
// Cleaned text channel: one result byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       end_of_text;

  modport source (output valid, output out_byte, output byte_valid,
                  output end_of_text, input ready);
  modport sink   (input valid, input out_byte, input byte_valid,
                  input end_of_text, output ready);
endinterface

>>> rtl/config_text_comment_stripper_top.sv
// ----------------------------------------------------------------------------
// config_text_comment_stripper_top
// Comment-stripping text filter for configuration text streams.
// ----------------------------------------------------------------------------
// Raw text enters on in_i, one byte per transfer, with last_byte on the final
// byte. Cleaned text leaves on out_o: each transfer carries a byte
// (byte_valid high) or, when the final byte yields nothing, a bare end marker;
// end_of_text marks the last result of the text.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i: 0 line-comment
// characters, 1 quote characters, 2 kept controls. The user must write them
// only while the block is idle; the block itself does not enforce this.
// A byte is held in the input register, then its results load the result
// register once it can take them, and the results are offered from there.
// Throughput: one text byte per cycle while each byte yields at most one
// result and the receiver is ready; a byte that yields more than one result
// holds the result register until the single output port has passed each on.
// When the receiver stalls, results wait in the result register and the next
// byte in the input register, and in_i.ready drops once both are full.
// Reset clears the scanner state and both registers and loads the default
// configuration; after the final byte the scanner returns to its reset state
// while the configuration is kept.
// ----------------------------------------------------------------------------
module config_text_comment_stripper_top import ccs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  ccs_in_if.sink             in_i,
  ccs_out_if.source          out_o
);

  logic [CommentW-1:0] comment_chars_q;
  logic [QuoteW-1:0]   quote_chars_q;
  logic [KeptW-1:0]    kept_controls_q;

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       can_load;
  logic       step;
  grp_t       grp;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_chars_q <= CommentReset;
      quote_chars_q   <= QuoteReset;
      kept_controls_q <= KeptReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgCommentChars: comment_chars_q <= cfg_data_i[CommentW-1:0];
        CfgQuoteChars:   quote_chars_q   <= cfg_data_i[QuoteW-1:0];
        CfgKeptControls: kept_controls_q <= cfg_data_i[KeptW-1:0];
        default: ;
      endcase
    end
  end

  // input register, freed when its byte moves into the result register
  assign step       = in_v_q && can_load;
  assign in_i.ready = !in_v_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.text_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  // per-byte scanner
  ccs_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .text_byte_i     (in_byte_q),
    .last_byte_i     (in_last_q),
    .comment_chars_i (comment_chars_q),
    .quote_chars_i   (quote_chars_q),
    .kept_controls_i (kept_controls_q),
    .grp_o           (grp)
  );

  // result register
  ccs_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .grp_i      (grp),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

>>> rtl/ccs_scan.sv
// ----------------------------------------------------------------------------
// ccs_scan
// Scanner state and per-byte logic: comment, quote and whitespace handling
// followed by the empty-line filter; yields up to three results per byte.
// ----------------------------------------------------------------------------
module ccs_scan import ccs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          text_byte_i,
  input  logic                last_byte_i,
  input  logic [CommentW-1:0] comment_chars_i,
  input  logic [QuoteW-1:0]   quote_chars_i,
  input  logic [KeptW-1:0]    kept_controls_i,
  output grp_t                grp_o
);

  typedef enum logic [1:0] {
    ModeNormal,
    ModeQuote,
    ModeLine,
    ModeBlock
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] open_quote_q, open_quote_d;
  logic       after_bs_q, after_bs_d;
  logic       after_star_q, after_star_d;
  logic       held_slash_q, held_slash_d;
  logic       line_content_q, line_content_d;
  logic       nl_pending_q, nl_pending_d;

  // character matches
  logic is_plain, is_quote, is_comment, is_kept;

  always_comb begin
    is_plain   = ((text_byte_i >= ChUpperA) && (text_byte_i <= ChUpperZ)) ||
                 ((text_byte_i >= ChDigit0) && (text_byte_i <= ChDigit9));
    is_quote   = 1'b0;
    is_comment = 1'b0;
    is_kept    = 1'b0;
    for (int i = 0; i < QuoteSlots; i++) begin
      if (quote_chars_i[8*i +: 8] == text_byte_i) is_quote = 1'b1;
    end
    for (int i = 0; i < CommentSlots; i++) begin
      if (comment_chars_i[8*i +: 8] == text_byte_i) is_comment = 1'b1;
    end
    for (int i = 0; i < KeptSlots; i++) begin
      if (kept_controls_i[8*i +: 8] == text_byte_i) is_kept = 1'b1;
    end
    // a zero byte never matches an unused slot
    if (text_byte_i == 8'h00) begin
      is_quote   = 1'b0;
      is_comment = 1'b0;
      is_kept    = 1'b0;
    end
  end

  // first stage: which bytes go on to the line filter
  logic [MaxResults-1:0] push_v;
  logic [7:0]            push_b [MaxResults];

  always_comb begin
    mode_d       = mode_q;
    open_quote_d = open_quote_q;
    after_bs_d   = after_bs_q;
    after_star_d = after_star_q;
    held_slash_d = held_slash_q;
    push_v       = '0;
    push_b[0]    = ChSlash;
    push_b[1]    = text_byte_i;
    push_b[2]    = ChSlash;

    case (mode_q)
      ModeQuote: begin
        push_v[1] = 1'b1;
        if ((text_byte_i == open_quote_q) && !after_bs_q) mode_d = ModeNormal;
        after_bs_d = (text_byte_i == ChBackslash);
      end
      ModeLine: begin
        if (text_byte_i == ChNewline) begin
          mode_d    = ModeNormal;
          push_v[1] = 1'b1;
        end
      end
      ModeBlock: begin
        if (after_star_q && (text_byte_i == ChSlash)) begin
          mode_d       = ModeNormal;
          after_star_d = 1'b0;
        end else begin
          after_star_d = (text_byte_i == ChStar);
        end
      end
      default: begin
        if (held_slash_q && (text_byte_i == ChSlash)) begin
          held_slash_d = 1'b0;
          mode_d       = ModeLine;
        end else if (held_slash_q && (text_byte_i == ChStar)) begin
          held_slash_d = 1'b0;
          mode_d       = ModeBlock;
          after_star_d = 1'b0;
        end else begin
          // a held slash that starts no comment goes out first
          push_v[0]    = held_slash_q;
          held_slash_d = 1'b0;
          if (is_plain) begin
            push_v[1] = 1'b1;
          end else if (is_quote) begin
            push_v[1]    = 1'b1;
            mode_d       = ModeQuote;
            open_quote_d = text_byte_i;
            after_bs_d   = (text_byte_i == ChBackslash);
          end else if (is_comment) begin
            mode_d = ModeLine;
          end else if (text_byte_i == ChSlash) begin
            held_slash_d = 1'b1;
          end else if ((text_byte_i > ChSpace) || is_kept) begin
            push_v[1] = 1'b1;
          end
        end
      end
    endcase

    // slash still held at end of text
    push_v[2] = last_byte_i && held_slash_d;
  end

  // second stage: drop empty lines and hold newlines until content follows
  logic [ResCntW-1:0] cnt;
  res_t               res [MaxResults];
  logic               lc_w, np_w;

  always_comb begin
    cnt  = '0;
    lc_w = line_content_q;
    np_w = nl_pending_q;
    for (int k = 0; k < MaxResults; k++) res[k] = '0;

    for (int j = 0; j < MaxResults; j++) begin
      if (push_v[j]) begin
        if (push_b[j] == ChNewline) begin
          if (lc_w) begin
            np_w = 1'b1;
            lc_w = 1'b0;
          end
        end else begin
          if (np_w && (cnt < ResCntW'(MaxResults))) begin
            res[cnt].out_byte   = ChNewline;
            res[cnt].byte_valid = 1'b1;
            cnt                 = cnt + 1'b1;
          end
          np_w = 1'b0;
          if (cnt < ResCntW'(MaxResults)) begin
            res[cnt].out_byte   = push_b[j];
            res[cnt].byte_valid = 1'b1;
            cnt                 = cnt + 1'b1;
          end
          lc_w = 1'b1;
        end
      end
    end

    // end of text marks the final result, or stands alone as a bare marker
    if (last_byte_i) begin
      if (cnt == '0) begin
        res[0].end_of_text = 1'b1;
        cnt                = ResCntW'(1);
      end else begin
        res[cnt - 1'b1].end_of_text = 1'b1;
      end
    end

    line_content_d = lc_w;
    nl_pending_d   = np_w;
  end

  always_comb begin
    grp_o.cnt = cnt;
    for (int k = 0; k < MaxResults; k++) grp_o.res[k] = res[k];
  end

  // scanner state, back to reset after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeNormal;
      open_quote_q   <= '0;
      after_bs_q     <= 1'b0;
      after_star_q   <= 1'b0;
      held_slash_q   <= 1'b0;
      line_content_q <= 1'b0;
      nl_pending_q   <= 1'b0;
    end else if (step_i) begin
      if (last_byte_i) begin
        mode_q         <= ModeNormal;
        open_quote_q   <= '0;
        after_bs_q     <= 1'b0;
        after_star_q   <= 1'b0;
        held_slash_q   <= 1'b0;
        line_content_q <= 1'b0;
        nl_pending_q   <= 1'b0;
      end else begin
        mode_q         <= mode_d;
        open_quote_q   <= open_quote_d;
        after_bs_q     <= after_bs_d;
        after_star_q   <= after_star_d;
        held_slash_q   <= held_slash_d;
        line_content_q <= line_content_d;
        nl_pending_q   <= nl_pending_d;
      end
    end
  end

endmodule

>>> rtl/ccs_obuf.sv
// ----------------------------------------------------------------------------
// ccs_obuf
// Result register: holds the results of one text byte and hands them out
// one per transfer, taking the next group as the last one leaves.
// ----------------------------------------------------------------------------
module ccs_obuf import ccs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  grp_t  grp_i,
  output logic  can_load_o,
  ccs_out_if.source out_o
);

  logic [ResCntW-1:0] cnt_q, cnt_d;
  res_t               slot_q [MaxResults];
  res_t               slot_d [MaxResults];
  logic               pop;

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = slot_q[0].out_byte;
  assign out_o.byte_valid  = slot_q[0].byte_valid;
  assign out_o.end_of_text = slot_q[0].end_of_text;

  assign pop        = out_o.valid && out_o.ready;
  assign can_load_o = (cnt_q == '0) || ((cnt_q == ResCntW'(1)) && out_o.ready);

  // load a new group or shift the next result to the front
  always_comb begin
    cnt_d = cnt_q;
    for (int k = 0; k < MaxResults; k++) slot_d[k] = slot_q[k];
    if (load_i) begin
      cnt_d = grp_i.cnt;
      for (int k = 0; k < MaxResults; k++) slot_d[k] = grp_i.res[k];
    end else if (pop) begin
      cnt_d = cnt_q - 1'b1;
      for (int k = 0; k < MaxResults - 1; k++) slot_d[k] = slot_q[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) slot_q[k] <= slot_d[k];
  end

endmodule
